// ===== hw/rtl/mie_pkg.sv =====
package mie_pkg;

  // operand width of the whole block
  localparam int unsigned WIDTH = 32;
  // shift count width, enough for 0 .. WIDTH-1
  localparam int unsigned KW = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [KW-1:0]    shamt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_STEP,
    ST_FIN
  } state_e;

  // sequencer to division unit
  typedef struct packed {
    logic load;
    logic shift;
    logic sub;
  } div_ctl_t;

  // division unit to sequencer
  typedef struct packed {
    logic can_shift;
    logic k_zero;
  } div_stat_t;

endpackage

// ===== hw/rtl/mie_divstep.sv =====
module mie_divstep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mie_pkg::div_ctl_t ctl_i,
  input  mie_pkg::word_t    dividend_i,
  input  mie_pkg::word_t    divisor_i,
  input  mie_pkg::word_t    acc_init_i,
  input  mie_pkg::word_t    coeff_i,
  output mie_pkg::word_t    rem_o,
  output mie_pkg::word_t    acc_o,
  output mie_pkg::div_stat_t stat_o
);
  import mie_pkg::*;

  word_t  rem_q, rem_d;
  word_t  acc_q, acc_d;
  word_t  d_q, d_d;
  word_t  sd_q, sd_d;
  shamt_t k_q, k_d;

  logic            fits;
  logic [WIDTH:0]  d_dbl;

  assign d_dbl = {d_q, 1'b0};
  assign fits  = (d_q <= rem_q);

  assign stat_o.can_shift = (d_dbl <= {1'b0, rem_q});
  assign stat_o.k_zero    = (k_q == '0);

  always_comb begin
    rem_d = rem_q;
    acc_d = acc_q;
    d_d   = d_q;
    sd_d  = sd_q;
    k_d   = k_q;
    if (ctl_i.load) begin
      rem_d = dividend_i;
      acc_d = acc_init_i;
      d_d   = divisor_i;
      sd_d  = coeff_i;
      k_d   = '0;
    end else if (ctl_i.shift) begin
      d_d  = {d_q[WIDTH-2:0], 1'b0};
      sd_d = {sd_q[WIDTH-2:0], 1'b0};
      k_d  = k_q + shamt_t'(1);
    end else if (ctl_i.sub) begin
      // one quotient bit: subtract the shifted divisor, add the shifted coefficient
      if (fits) begin
        rem_d = rem_q - d_q;
        acc_d = acc_q + sd_q;
      end
      if (k_q != '0) begin
        d_d  = {1'b0, d_q[WIDTH-1:1]};
        sd_d = {1'b0, sd_q[WIDTH-1:1]};
        k_d  = k_q - shamt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    d_q   <= d_d;
    sd_q  <= sd_d;
  end

  assign rem_o = rem_q;
  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/modular_inverse_ext_euclid_unit.sv =====
// modular inverse by iterative extended euclid
//
// request channel: drive value_i and modulus_i and raise start; the request is
// taken at a rising edge where start is high and busy is low. busy stays high
// from the next cycle until the result is out.
// result channel: inverse_o, has_inverse_o and common_divisor_o are valid for
// exactly one cycle, marked by done_o. the receiver cannot stall; the result
// must be taken in that cycle. busy drops in the same cycle done_o rises, so a
// new request may be issued right then.
// each euclid step runs one shared shift/subtract/accumulate unit: a load in
// the check state, alignment shifts of the divisor, then restoring subtract
// steps, one quotient bit per step, a zero quotient still taking one subtract
// step, and a final step state that moves the remainder chain on. the longest
// runs for 32-bit operands come from consecutive fibonacci numbers. a zero
// modulus goes from the check state straight to the finish state.
// reset: the sequencer returns to idle, busy and done_o drop; no result is
// pending after reset.
module modular_inverse_ext_euclid_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mie_pkg::word_t value_i,
  input  mie_pkg::word_t modulus_i,
  output logic           done_o,
  output mie_pkg::word_t inverse_o,
  output logic           has_inverse_o,
  output mie_pkg::word_t common_divisor_o
);
  import mie_pkg::*;

  state_e state_q, state_d;

  // remainder chain and coefficient magnitudes
  word_t r_prev_q, r_prev_d;
  word_t r_cur_q, r_cur_d;
  word_t s_prev_q, s_prev_d;
  word_t s_cur_q, s_cur_d;
  word_t m_q, m_d;
  // parity of the step count, gives the sign of s_prev
  logic  idx_q, idx_d;

  // result registers
  logic  done_q, done_d;
  word_t inv_q, inv_d;
  logic  ok_q, ok_d;
  word_t gcd_q, gcd_d;

  div_ctl_t  div_ctl;
  div_stat_t div_stat;
  word_t     div_rem;
  word_t     div_acc;

  logic  accept;
  logic  gcd_one;
  word_t red;

  assign accept = start && !busy;

  mie_divstep u_divstep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (r_prev_q),
    .divisor_i  (r_cur_q),
    .acc_init_i (s_prev_q),
    .coeff_i    (s_cur_q),
    .rem_o      (div_rem),
    .acc_o      (div_acc),
    .stat_o     (div_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // remainder zero ends the chain
        if (r_cur_q == '0) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (!div_stat.can_shift) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        if (div_stat.k_zero) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        state_d = ST_CHECK;
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_ctl = '0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_CHECK: begin
        div_ctl.load = (r_cur_q != '0);
      end
      ST_ALIGN: begin
        div_ctl.shift = div_stat.can_shift;
      end
      ST_SUB: begin
        div_ctl.sub = 1'b1;
      end
      default: begin
        div_ctl = '0;
      end
    endcase
  end

  // final reduction: s_prev never exceeds twice the modulus, one compare/subtract
  assign gcd_one = (r_prev_q == word_t'(1)) && (m_q != '0);
  assign red     = (s_prev_q >= m_q) ? (s_prev_q - m_q) : s_prev_q;

  // datapath registers
  always_comb begin
    r_prev_d = r_prev_q;
    r_cur_d  = r_cur_q;
    s_prev_d = s_prev_q;
    s_cur_d  = s_cur_q;
    m_d      = m_q;
    idx_d    = idx_q;
    done_d   = 1'b0;
    inv_d    = inv_q;
    ok_d     = ok_q;
    gcd_d    = gcd_q;
    if (accept) begin
      r_prev_d = value_i;
      r_cur_d  = modulus_i;
      s_prev_d = word_t'(1);
      s_cur_d  = '0;
      m_d      = modulus_i;
      idx_d    = 1'b0;
    end
    if (state_q == ST_STEP) begin
      // shift the chain by one euclid step
      r_prev_d = r_cur_q;
      r_cur_d  = div_rem;
      s_prev_d = s_cur_q;
      s_cur_d  = div_acc;
      idx_d    = ~idx_q;
    end
    if (state_q == ST_FIN) begin
      done_d = 1'b1;
      gcd_d  = r_prev_q;
      ok_d   = gcd_one;
      if (!gcd_one) begin
        inv_d = '0;
      end else if (!idx_q || red == '0) begin
        inv_d = red;
      end else begin
        // odd step count means negative coefficient
        inv_d = m_q - red;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_prev_q <= r_prev_d;
    r_cur_q  <= r_cur_d;
    s_prev_q <= s_prev_d;
    s_cur_q  <= s_cur_d;
    m_q      <= m_d;
    idx_q    <= idx_d;
    inv_q    <= inv_d;
    ok_q     <= ok_d;
    gcd_q    <= gcd_d;
  end

  assign done_o           = done_q;
  assign inverse_o        = inv_q;
  assign has_inverse_o    = ok_q;
  assign common_divisor_o = gcd_q;

endmodule
